### hdl/assert_macros.svh
// Assertion macros for the checker file of the clip rectangle stack.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clip rect stack: assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clip rect stack: assertion failed");

`endif

### hdl/crs_pkg.sv
// Types, codes and micro-program for the clip rectangle stack.
// No dependencies; imported by every module of the block.
package crs_pkg;

  localparam int unsigned CRS_STACK_DEPTH = 16;
  localparam int unsigned COORD_W = 15;
  localparam int unsigned IN_W    = 16;
  localparam int unsigned WORD_W  = 18;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic signed [WORD_W-1:0] word_t;

  localparam coord_t SCREEN_W_RESET = 15'd640;
  localparam coord_t SCREEN_H_RESET = 15'd480;

  typedef struct packed {
    coord_t h;
    coord_t w;
    coord_t y;
    coord_t x;
  } rect_t;

  typedef enum logic [1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_RENDERER      = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_FULL  = 2'd1,
    ACT_LIMIT = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    FLT_NONE  = 2'd0,
    FLT_FULL  = 2'd1,
    FLT_EMPTY = 2'd2
  } fault_e;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MAX  = 3'd2,
    OP_MIN  = 3'd3,
    OP_GT   = 3'd4,
    OP_KILL = 3'd5
  } alu_op_e;

  typedef enum logic [3:0] {
    SRC_POS  = 4'd0,
    SRC_LEN  = 4'd1,
    SRC_LIM  = 4'd2,
    SRC_T    = 4'd3,
    SRC_TL   = 4'd4,
    SRC_A    = 4'd5,
    SRC_P    = 4'd6,
    SRC_E    = 4'd7,
    SRC_L    = 4'd8,
    SRC_ZERO = 4'd9
  } src_e;

  typedef enum logic [2:0] {
    DST_NONE = 3'd0,
    DST_A    = 3'd1,
    DST_P    = 3'd2,
    DST_E    = 3'd3,
    DST_L    = 3'd4,
    DST_T    = 3'd5,
    DST_TL   = 3'd6
  } dst_e;

  typedef struct packed {
    alu_op_e op;
    src_e    a;
    src_e    b;
    dst_e    dst;
  } uop_t;

  typedef struct packed {
    word_t res;
    logic  gt;
  } alu_res_t;

  localparam int unsigned UC_STEPS = 14;
  typedef logic [3:0] step_t;
  localparam step_t UC_LAST = 4'(UC_STEPS - 1);

  // Per-axis program: clamp (pos, len) to [0, lim], then cut the total (t, tl).
  function automatic uop_t uop_at(step_t s);
    uop_t u;
    case (s)
      4'd0:    u = '{op: OP_ADD,  a: SRC_POS, b: SRC_LEN,  dst: DST_A};
      4'd1:    u = '{op: OP_MAX,  a: SRC_POS, b: SRC_ZERO, dst: DST_P};
      4'd2:    u = '{op: OP_MAX,  a: SRC_A,   b: SRC_P,    dst: DST_E};
      4'd3:    u = '{op: OP_GT,   a: SRC_P,   b: SRC_LIM,  dst: DST_NONE};
      4'd4:    u = '{op: OP_MIN,  a: SRC_E,   b: SRC_LIM,  dst: DST_E};
      4'd5:    u = '{op: OP_SUB,  a: SRC_E,   b: SRC_P,    dst: DST_L};
      4'd6:    u = '{op: OP_KILL, a: SRC_ZERO, b: SRC_ZERO, dst: DST_NONE};
      4'd7:    u = '{op: OP_ADD,  a: SRC_T,   b: SRC_TL,   dst: DST_A};
      4'd8:    u = '{op: OP_MAX,  a: SRC_T,   b: SRC_P,    dst: DST_T};
      4'd9:    u = '{op: OP_MAX,  a: SRC_A,   b: SRC_T,    dst: DST_A};
      4'd10:   u = '{op: OP_ADD,  a: SRC_P,   b: SRC_L,    dst: DST_E};
      4'd11:   u = '{op: OP_MIN,  a: SRC_A,   b: SRC_E,    dst: DST_A};
      4'd12:   u = '{op: OP_SUB,  a: SRC_A,   b: SRC_T,    dst: DST_A};
      4'd13:   u = '{op: OP_MAX,  a: SRC_A,   b: SRC_ZERO, dst: DST_TL};
      default: u = '{op: OP_ADD,  a: SRC_ZERO, b: SRC_ZERO, dst: DST_NONE};
    endcase
    return u;
  endfunction

  function automatic word_t zext_coord(coord_t v);
    return word_t'({{(WORD_W-COORD_W){1'b0}}, v});
  endfunction

  function automatic word_t zext_in(logic [IN_W-1:0] v);
    return word_t'({{(WORD_W-IN_W){1'b0}}, v});
  endfunction

  function automatic word_t sext_in(logic [IN_W-1:0] v);
    return word_t'({{(WORD_W-IN_W){v[IN_W-1]}}, v});
  endfunction

endpackage

### hdl/crs_alu.sv
// Shared add / subtract / compare unit of the clip rectangle stack.
// Depends on crs_pkg.
module crs_alu import crs_pkg::*; (
  input  alu_op_e  op_i,
  input  word_t    a_i,
  input  word_t    b_i,
  output alu_res_t res_o
);

  logic [WORD_W:0] a_x;
  logic [WORD_W:0] b_x;
  logic [WORD_W:0] sum;
  logic            sub;
  logic            neg;

  // One adder serves every op; compares read the sign of a - b.
  assign sub = (op_i != OP_ADD);
  assign a_x = {a_i[WORD_W-1], a_i};
  assign b_x = {b_i[WORD_W-1], b_i};
  assign sum = a_x + (sub ? ~b_x : b_x) + {{WORD_W{1'b0}}, sub};
  assign neg = sum[WORD_W];

  always_comb begin
    res_o.gt = !neg && (sum != '0);
    case (op_i)
      OP_ADD, OP_SUB: res_o.res = word_t'(sum[WORD_W-1:0]);
      OP_MAX:         res_o.res = neg ? b_i : a_i;
      OP_MIN:         res_o.res = neg ? a_i : b_i;
      default:        res_o.res = a_i;
    endcase
  end

endmodule

### hdl/crs_stack_mem.sv
// Storage for the per-level clip totals, one write and one registered read port.
// Depends on crs_pkg.
module crs_stack_mem import crs_pkg::*; #(
  parameter  int unsigned DEPTH = CRS_STACK_DEPTH,
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  rect_t            wr_data_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output rect_t            rd_data_o
);

  rect_t mem_q [DEPTH];
  rect_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/clip_rect_stack.sv
// Push: for each axis a load and 14 ALU steps, then finish.
// Pop: through ST_READ (one stack memory read) with levels left, straight to ST_FINISH to empty or on fault.
// Push on a full stack: straight to ST_FINISH. Next item is taken in the cycle after the result
// leaves the sequencer; the shared ALU, one op per cycle, sets the push time.
// Reset: stack empty, screen 640 x 480, renderer attached; the stack memory
// itself is not cleared, only levels below the count are ever read.
module clip_rect_stack import crs_pkg::*; #(
  parameter int unsigned STACK_DEPTH = CRS_STACK_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [COORD_W-1:0]     cfg_data_i,
  // request items
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   req_type_i,
  input  logic signed [IN_W-1:0] rect_x_i,
  input  logic signed [IN_W-1:0] rect_y_i,
  input  logic [IN_W-1:0]        rect_w_i,
  input  logic [IN_W-1:0]        rect_h_i,
  // result items
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [COORD_W-1:0]     clip_x_o,
  output logic [COORD_W-1:0]     clip_y_o,
  output logic [COORD_W-1:0]     clip_w_o,
  output logic [COORD_W-1:0]     clip_h_o,
  output logic [1:0]             action_o,
  output logic [1:0]             fault_o
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // One-hot sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOAD   = 5'b00010,
    ST_RUN    = 5'b00100,
    ST_READ   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e     state_q;
  logic [CNT_W-1:0] cnt_q;
  logic       axis_q;
  step_t      step_q;

  // configuration registers
  coord_t     screen_w_q;
  coord_t     screen_h_q;
  logic       attached_q;

  // latched request
  logic signed [IN_W-1:0] x_q;
  logic signed [IN_W-1:0] y_q;
  logic [IN_W-1:0]        w_q;
  logic [IN_W-1:0]        h_q;
  fault_e     fault_q;
  fault_e     fault_d;

  // ALU working registers
  word_t      pos_q, len_q, lim_q, t_q, tl_q, a_q, p_q, e_q, l_q;
  logic       flag_q;

  // totals
  rect_t      top_q;
  rect_t      cur;
  coord_t     new_x_q;
  coord_t     new_w_q;
  rect_t      push_rect;

  // output register
  logic       out_valid_q;
  coord_t     clip_x_q, clip_y_q, clip_w_q, clip_h_q;
  action_e    action_q;
  action_e    action_d;
  fault_e     fault_out_q;

  uop_t       uop;
  word_t      opa;
  word_t      opb;
  alu_res_t   alu_res;

  logic       accept;
  logic       finish_fire;
  logic       last_step;
  logic       mem_wr;
  logic       mem_rd;
  logic [CNT_W-1:0] cnt_m2;
  rect_t      rd_data;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign finish_fire = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
  assign last_step   = (state_q == ST_RUN) && (step_q == UC_LAST);

  // Total of the top level; an empty stack means the full screen.
  always_comb begin
    if (cnt_q == '0) begin
      cur = '{h: screen_h_q, w: screen_w_q, y: '0, x: '0};
    end else begin
      cur = top_q;
    end
  end

  // Fault decision made at accept time.
  always_comb begin
    fault_d = FLT_NONE;
    if (!req_type_i) begin
      if (cnt_q >= CNT_W'(STACK_DEPTH)) fault_d = FLT_FULL;
    end else begin
      if (cnt_q == '0) fault_d = FLT_EMPTY;
    end
  end

  // Micro-program word and operand selection for the shared ALU.
  assign uop = uop_at(step_q);

  always_comb begin
    case (uop.a)
      SRC_POS: opa = pos_q;
      SRC_LEN: opa = len_q;
      SRC_LIM: opa = lim_q;
      SRC_T:   opa = t_q;
      SRC_TL:  opa = tl_q;
      SRC_A:   opa = a_q;
      SRC_P:   opa = p_q;
      SRC_E:   opa = e_q;
      SRC_L:   opa = l_q;
      default: opa = '0;
    endcase
  end

  always_comb begin
    case (uop.b)
      SRC_POS: opb = pos_q;
      SRC_LEN: opb = len_q;
      SRC_LIM: opb = lim_q;
      SRC_T:   opb = t_q;
      SRC_TL:  opb = tl_q;
      SRC_A:   opb = a_q;
      SRC_P:   opb = p_q;
      SRC_E:   opb = e_q;
      SRC_L:   opb = l_q;
      default: opb = '0;
    endcase
  end

  crs_alu u_alu (
    .op_i  (uop.op),
    .a_i   (opa),
    .b_i   (opb),
    .res_o (alu_res)
  );

  // The new total once the vertical axis finishes.
  assign push_rect = '{h: alu_res.res[COORD_W-1:0], w: new_w_q,
                       y: t_q[COORD_W-1:0],        x: new_x_q};

  // Stack memory: write on push completion, read the level below on pop.
  assign mem_wr = last_step && axis_q;
  assign mem_rd = accept && req_type_i && (cnt_q > CNT_W'(1));
  assign cnt_m2 = cnt_q - CNT_W'(2);

  crs_stack_mem #(
    .DEPTH (STACK_DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr),
    .wr_addr_i (cnt_q[IDX_W-1:0]),
    .wr_data_i (push_rect),
    .rd_en_i   (mem_rd),
    .rd_addr_i (cnt_m2[IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  // Action reported with the total after the item.
  always_comb begin
    if (!attached_q) begin
      action_d = ACT_NONE;
    end else if (cur.x == '0 && cur.y == '0 && cur.w == screen_w_q &&
                 cur.h == screen_h_q) begin
      action_d = ACT_FULL;
    end else begin
      action_d = ACT_LIMIT;
    end
  end

  // Sequencer and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      axis_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      screen_w_q  <= SCREEN_W_RESET;
      screen_h_q  <= SCREEN_H_RESET;
      attached_q  <= 1'b1;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SCREEN_WIDTH:  screen_w_q <= cfg_data_i;
          CFG_SCREEN_HEIGHT: screen_h_q <= cfg_data_i;
          CFG_RENDERER:      attached_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      // load a fresh result when finishing, else drop a taken one
      if (finish_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (fault_d != FLT_NONE) begin
              state_q <= ST_FINISH;
            end else if (!req_type_i) begin
              axis_q  <= 1'b0;
              state_q <= ST_LOAD;
            end else begin
              cnt_q   <= cnt_q - CNT_W'(1);
              state_q <= (cnt_q > CNT_W'(1)) ? ST_READ : ST_FINISH;
            end
          end
        end
        ST_LOAD: begin
          step_q  <= '0;
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          if (step_q == UC_LAST) begin
            if (!axis_q) begin
              axis_q  <= 1'b1;
              state_q <= ST_LOAD;
            end else begin
              cnt_q   <= cnt_q + CNT_W'(1);
              state_q <= ST_FINISH;
            end
          end else begin
            step_q <= step_q + step_t'(1);
          end
        end
        ST_READ: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (finish_fire) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q     <= rect_x_i;
      y_q     <= rect_y_i;
      w_q     <= rect_w_i;
      h_q     <= rect_h_i;
      fault_q <= fault_d;
    end

    if (state_q == ST_LOAD) begin
      // Hold one axis at a time in the working registers.
      pos_q  <= axis_q ? sext_in(y_q) : sext_in(x_q);
      len_q  <= axis_q ? zext_in(h_q) : zext_in(w_q);
      lim_q  <= axis_q ? zext_coord(screen_h_q) : zext_coord(screen_w_q);
      t_q    <= axis_q ? zext_coord(cur.y) : zext_coord(cur.x);
      tl_q   <= axis_q ? zext_coord(cur.h) : zext_coord(cur.w);
      // no renderer: the pushed rectangle collapses to zero width and height
      flag_q <= !attached_q;
    end

    if (state_q == ST_RUN) begin
      case (uop.dst)
        DST_A:   a_q  <= alu_res.res;
        DST_P:   p_q  <= alu_res.res;
        DST_E:   e_q  <= alu_res.res;
        DST_L:   l_q  <= alu_res.res;
        DST_T:   t_q  <= alu_res.res;
        DST_TL:  tl_q <= alu_res.res;
        default: ;
      endcase
      if (uop.op == OP_GT) flag_q <= flag_q | alu_res.gt;
      // left or top edge past the screen: zero the clamped axis
      if (uop.op == OP_KILL && flag_q) begin
        p_q <= '0;
        l_q <= '0;
      end
      if (last_step && !axis_q) begin
        new_x_q <= t_q[COORD_W-1:0];
        new_w_q <= alu_res.res[COORD_W-1:0];
      end
    end

    if (mem_wr) top_q <= push_rect;
    if (state_q == ST_READ) top_q <= rd_data;

    if (finish_fire) begin
      clip_x_q    <= cur.x;
      clip_y_q    <= cur.y;
      clip_w_q    <= cur.w;
      clip_h_q    <= cur.h;
      action_q    <= action_d;
      fault_out_q <= fault_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign clip_x_o    = clip_x_q;
  assign clip_y_o    = clip_y_q;
  assign clip_w_o    = clip_w_q;
  assign clip_h_o    = clip_h_q;
  assign action_o    = action_q;
  assign fault_o     = fault_out_q;

endmodule

### hdl/crs_checker.sv
// Port-level checks for the clip rectangle stack, bound to its top level.
// Depends on crs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module crs_checker import crs_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [COORD_W-1:0] clip_x_i,
  input logic [COORD_W-1:0] clip_y_i,
  input logic [COORD_W-1:0] clip_w_i,
  input logic [1:0]         action_i,
  input logic [1:0]         fault_i
);

  // The sequencer is busy in the cycle after taking an item.
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)

  // A stalled result holds.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(clip_x_i) && $stable(clip_w_i) && $stable(action_i) && $stable(fault_i))

  // Removing the limit means the total starts at the origin.
  `ASSERT_IMPL(a_full_at_origin, clk_i, rst_ni, out_valid_i && action_i == ACT_FULL, clip_x_i == '0 && clip_y_i == '0)

  // A pop on an empty stack reports the full screen, never a limit.
  `ASSERT_IMPL(a_empty_no_limit, clk_i, rst_ni, out_valid_i && fault_i == FLT_EMPTY, action_i != ACT_LIMIT)

endmodule

bind clip_rect_stack crs_checker u_crs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .clip_x_i    (clip_x_o),
  .clip_y_i    (clip_y_o),
  .clip_w_i    (clip_w_o),
  .action_i    (action_o),
  .fault_i     (fault_o)
);
